// ===== design/tss_pkg.sv =====
// ----------------------------------------------------------------------------
// tss_pkg
// Shared types and constants of the tdma slot sequencer: request payloads,
// action and phase codes, slot roles, node addresses and register map.
// ----------------------------------------------------------------------------
package tss_pkg;

  localparam int unsigned TIME_W   = 48;
  localparam int unsigned FLEN_W   = 24;
  localparam int unsigned SLEN_W   = 20;
  localparam int unsigned FRAME_W  = 16;
  localparam int unsigned SLOT_W   = 8;
  localparam int unsigned ADDR_W   = 8;
  localparam int unsigned ROLE_W   = 3;
  localparam int unsigned CNT_W    = 6;
  localparam int unsigned PADDR_W  = 6;
  localparam int unsigned PDATA_W  = 64;

  localparam logic [SLEN_W-1:0] TURNAROUND_US = 20'd4096;

  // node addresses
  localparam logic [ADDR_W-1:0] ADDR_MASTER     = 8'h21;
  localparam logic [ADDR_W-1:0] ADDR_AIRCRAFT   = 8'h31;
  localparam logic [ADDR_W-1:0] ADDR_ANCHOR1    = 8'h22;
  localparam logic [ADDR_W-1:0] ADDR_ANCHOR2    = 8'h23;
  localparam logic [ADDR_W-1:0] ADDR_UNASSIGNED = 8'h00;
  localparam logic [ADDR_W-1:0] ADDR_BROADCAST  = 8'hff;

  localparam logic [3:0][ADDR_W-1:0] NODE_ADDR =
    {ADDR_ANCHOR2, ADDR_ANCHOR1, ADDR_AIRCRAFT, ADDR_MASTER};

  // slot roles
  localparam logic [ROLE_W-1:0] ROLE_UNUSED   = 3'd0;
  localparam logic [ROLE_W-1:0] ROLE_MASTER   = 3'd1;
  localparam logic [ROLE_W-1:0] ROLE_AIRCRAFT = 3'd2;
  localparam logic [ROLE_W-1:0] ROLE_ANCHOR1  = 3'd3;
  localparam logic [ROLE_W-1:0] ROLE_ANCHOR2  = 3'd4;
  localparam logic [ROLE_W-1:0] ROLE_JOIN     = 3'd5;

  localparam logic [3:0][ROLE_W-1:0] NODE_ROLE =
    {ROLE_ANCHOR2, ROLE_ANCHOR1, ROLE_AIRCRAFT, ROLE_MASTER};

  // register indexes
  localparam logic [2:0] REG_LOCAL_NODE   = 3'd0;
  localparam logic [2:0] REG_CLOCK_LOCKED = 3'd1;
  localparam logic [2:0] REG_FRAME_START  = 3'd2;
  localparam logic [2:0] REG_FRAME_BASE   = 3'd3;
  localparam logic [2:0] REG_FRAME_LEN    = 3'd4;
  localparam logic [2:0] REG_SLOT_LEN     = 3'd5;
  localparam logic [2:0] REG_GUARD_LEN    = 3'd6;
  localparam logic [2:0] REG_ACTIVE_NODES = 3'd7;

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_EDGE = 1'b1;

  typedef enum logic [2:0] {
    ACT_WAIT        = 3'd0,
    ACT_SET_CHANNEL = 3'd1,
    ACT_START_TX    = 3'd2,
    ACT_START_RX    = 3'd3,
    ACT_STOP        = 3'd4,
    ACT_LOG_RX      = 3'd5
  } action_t;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_SLOT_START = 4'd1,
    PH_SWITCH     = 4'd2,
    PH_TX         = 4'd3,
    PH_RX         = 4'd4,
    PH_RX_DONE    = 4'd5,
    PH_TX_DONE    = 4'd6,
    PH_SETTLING   = 4'd7,
    PH_GUARD      = 4'd8,
    PH_SLOT_DONE  = 4'd9
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_FRAME,
    ST_DIV_SLOT,
    ST_DIV_LAST,
    ST_DECIDE
  } seq_state_t;

  typedef struct packed {
    logic              func;
    logic [TIME_W-1:0] now_time;
  } in_item_t;

  typedef struct packed {
    action_t            action;
    phase_t             phase;
    logic [FRAME_W-1:0] frame_number;
    logic [SLOT_W-1:0]  slot_number;
    logic [SLEN_W-1:0]  slot_offset;
    logic               we_transmit;
    logic [ROLE_W-1:0]  slot_role;
    logic [ADDR_W-1:0]  transmitter;
  } out_item_t;

endpackage

// ===== design/tdma_slot_sequencer.sv =====
// ----------------------------------------------------------------------------
// tdma_slot_sequencer
// TDMA slot sequencer: splits tick time into frame, slot and slot offset and
// issues radio actions (set channel, start tx/rx, stop, log rx).
// ----------------------------------------------------------------------------
// A tick request (func 0) returns exactly one result; an edge request (func 1)
// only marks a pending radio edge and returns nothing. A tick while unlocked
// or before frame start skips the divider. Any other tick runs three
// divisions one after another through a single restoring divider that
// retires one quotient bit per cycle: elapsed time by frame length (48
// steps), frame position by slot length (24 steps) and frame length by slot
// length for the join slot index (24 steps), before its result is
// registered. The divider is the rate limit.
// The result sits in an output register, so a new request may be taken while
// the previous result still waits on out_ready. Registers sit on an APB-style
// port at byte address 8*index with 64-bit data; write them only while idle.
// ----------------------------------------------------------------------------
module tdma_slot_sequencer
  import tss_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // request channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_item,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_item,
  // configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready
);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [ADDR_W-1:0]  local_node_r;
  logic               clock_locked_r;
  logic [TIME_W-1:0]  frame_start_r;
  logic [FRAME_W-1:0] frame_base_r;
  logic [FLEN_W-1:0]  frame_len_r;
  logic [SLEN_W-1:0]  slot_len_r;
  logic [SLEN_W-1:0]  guard_len_r;
  logic [3:0]         active_nodes_r;

  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[5:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_node_r   <= '0;
      clock_locked_r <= 1'b0;
      frame_start_r  <= '0;
      frame_base_r   <= '0;
      frame_len_r    <= FLEN_W'(1);
      slot_len_r     <= SLEN_W'(1);
      guard_len_r    <= '0;
      active_nodes_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_LOCAL_NODE:   local_node_r   <= pwdata[ADDR_W-1:0];
        REG_CLOCK_LOCKED: clock_locked_r <= pwdata[0];
        REG_FRAME_START:  frame_start_r  <= pwdata[TIME_W-1:0];
        REG_FRAME_BASE:   frame_base_r   <= pwdata[FRAME_W-1:0];
        REG_FRAME_LEN:    frame_len_r    <= pwdata[FLEN_W-1:0];
        REG_SLOT_LEN:     slot_len_r     <= pwdata[SLEN_W-1:0];
        REG_GUARD_LEN:    guard_len_r    <= pwdata[SLEN_W-1:0];
        REG_ACTIVE_NODES: active_nodes_r <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      REG_LOCAL_NODE:   prdata = PDATA_W'(local_node_r);
      REG_CLOCK_LOCKED: prdata = PDATA_W'(clock_locked_r);
      REG_FRAME_START:  prdata = PDATA_W'(frame_start_r);
      REG_FRAME_BASE:   prdata = PDATA_W'(frame_base_r);
      REG_FRAME_LEN:    prdata = PDATA_W'(frame_len_r);
      REG_SLOT_LEN:     prdata = PDATA_W'(slot_len_r);
      REG_GUARD_LEN:    prdata = PDATA_W'(guard_len_r);
      REG_ACTIVE_NODES: prdata = PDATA_W'(active_nodes_r);
      default:          prdata = '0;
    endcase
  end

  // zero lengths count as one
  logic [FLEN_W-1:0] flen_eff;
  logic [SLEN_W-1:0] slen_eff;
  assign flen_eff = (frame_len_r == '0) ? FLEN_W'(1) : frame_len_r;
  assign slen_eff = (slot_len_r  == '0) ? SLEN_W'(1) : slot_len_r;

  // --------------------------------------------------------------------------
  // shared restoring divider, one quotient bit per cycle
  // --------------------------------------------------------------------------
  logic [TIME_W-1:0]  dvd_r, dvd_nxt;     // dividend, shifted out msb first
  logic [FLEN_W-1:0]  rem_r, rem_nxt;     // partial remainder
  logic [FLEN_W-1:0]  dvs_r, dvs_nxt;     // divisor
  logic [FRAME_W-1:0] quo_r, quo_nxt;     // low quotient bits only
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;     // steps left minus one

  logic [FLEN_W+1:0]  trial;
  logic               q_bit;
  logic [FLEN_W-1:0]  rem_step;
  logic [FRAME_W-1:0] quo_step;

  assign trial    = {1'b0, rem_r, dvd_r[TIME_W-1]} - {2'b00, dvs_r};
  assign q_bit    = ~trial[FLEN_W+1];
  assign rem_step = q_bit ? trial[FLEN_W-1:0] : {rem_r[FLEN_W-2:0], dvd_r[TIME_W-1]};
  assign quo_step = {quo_r[FRAME_W-2:0], q_bit};

  // --------------------------------------------------------------------------
  // sequencer and slot state
  // --------------------------------------------------------------------------
  seq_state_t state_r, state_nxt;

  logic               idle_tick_r, idle_tick_nxt;   // unlocked or early tick
  logic [FRAME_W-1:0] frame_calc_r, frame_calc_nxt;
  logic [SLOT_W-1:0]  slot_calc_r, slot_calc_nxt;
  logic [SLEN_W-1:0]  spos_r, spos_nxt;
  logic [SLOT_W-1:0]  last_r, last_nxt;

  logic [FRAME_W-1:0] cur_frame_r, cur_frame_nxt;
  logic [SLOT_W-1:0]  cur_slot_r, cur_slot_nxt;
  logic               slot_known_r, slot_known_nxt;
  phase_t             phase_r, phase_nxt;
  logic [ROLE_W-1:0]  role_r, role_nxt;
  logic [ADDR_W-1:0]  sender_r, sender_nxt;
  logic               channel_done_r, channel_done_nxt;
  logic               radio_on_r, radio_on_nxt;
  logic               edge_pending_r, edge_pending_nxt;

  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r, out_item_nxt;

  logic               in_acc;
  logic               emit;
  action_t            act;
  logic [SLEN_W-1:0]  offset;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid & in_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // slot owner from the compacted active mask
  logic [ROLE_W-1:0] asg_role;
  logic [ADDR_W-1:0] asg_sender;

  always_comb begin
    logic [2:0] seen;
    seen       = '0;
    asg_role   = ROLE_UNUSED;
    asg_sender = ADDR_BROADCAST;
    if (slot_calc_r == last_r) begin
      asg_role   = ROLE_JOIN;
      asg_sender = ADDR_UNASSIGNED;
    end else begin
      for (int i = 0; i < 4; i++) begin
        if (active_nodes_r[i]) begin
          if ({5'b0, seen} == slot_calc_r) begin
            asg_role   = NODE_ROLE[i];
            asg_sender = NODE_ADDR[i];
          end
          seen = seen + 3'd1;
        end
      end
    end
  end

  // guard threshold saturates at zero when the guard exceeds the slot
  logic [SLEN_W-1:0] threshold;
  logic              in_guard;
  logic              in_settle_zone;
  logic              new_slot;

  assign threshold      = (guard_len_r > slen_eff) ? '0 : slen_eff - guard_len_r;
  assign in_guard       = (spos_r >= threshold);
  assign in_settle_zone = in_guard | (spos_r >= TURNAROUND_US);
  assign new_slot       = ~slot_known_r | (cur_frame_r != frame_calc_r)
                        | (cur_slot_r != slot_calc_r);

  logic [TIME_W-1:0] elapsed;
  logic              early;
  assign elapsed = in_item.now_time - frame_start_r;
  assign early   = (in_item.now_time < frame_start_r);

  always_comb begin
    state_nxt        = state_r;
    dvd_nxt          = dvd_r;
    rem_nxt          = rem_r;
    dvs_nxt          = dvs_r;
    quo_nxt          = quo_r;
    cnt_nxt          = cnt_r;
    idle_tick_nxt    = idle_tick_r;
    frame_calc_nxt   = frame_calc_r;
    slot_calc_nxt    = slot_calc_r;
    spos_nxt         = spos_r;
    last_nxt         = last_r;
    cur_frame_nxt    = cur_frame_r;
    cur_slot_nxt     = cur_slot_r;
    slot_known_nxt   = slot_known_r;
    phase_nxt        = phase_r;
    role_nxt         = role_r;
    sender_nxt       = sender_r;
    channel_done_nxt = channel_done_r;
    radio_on_nxt     = radio_on_r;
    edge_pending_nxt = edge_pending_r;
    emit             = 1'b0;
    act              = ACT_WAIT;
    offset           = spos_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_item.func == FUNC_EDGE) begin
            edge_pending_nxt = 1'b1;
          end else if (!clock_locked_r || early) begin
            idle_tick_nxt = 1'b1;
            state_nxt     = ST_DECIDE;
          end else begin
            // elapsed time / frame length
            idle_tick_nxt = 1'b0;
            dvd_nxt       = elapsed;
            rem_nxt       = '0;
            quo_nxt       = '0;
            dvs_nxt       = flen_eff;
            cnt_nxt       = CNT_W'(TIME_W - 1);
            state_nxt     = ST_DIV_FRAME;
          end
        end
      end

      ST_DIV_FRAME: begin
        dvd_nxt = {dvd_r[TIME_W-2:0], 1'b0};
        rem_nxt = rem_step;
        quo_nxt = quo_step;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          // frame position / slot length
          frame_calc_nxt = frame_base_r + quo_step;
          dvd_nxt        = {rem_step, {(TIME_W-FLEN_W){1'b0}}};
          rem_nxt        = '0;
          quo_nxt        = '0;
          dvs_nxt        = FLEN_W'(slen_eff);
          cnt_nxt        = CNT_W'(FLEN_W - 1);
          state_nxt      = ST_DIV_SLOT;
        end
      end

      ST_DIV_SLOT: begin
        dvd_nxt = {dvd_r[TIME_W-2:0], 1'b0};
        rem_nxt = rem_step;
        quo_nxt = quo_step;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          // frame length / slot length gives the join slot
          slot_calc_nxt = quo_step[SLOT_W-1:0];
          spos_nxt      = rem_step[SLEN_W-1:0];
          dvd_nxt       = {flen_eff, {(TIME_W-FLEN_W){1'b0}}};
          rem_nxt       = '0;
          quo_nxt       = '0;
          cnt_nxt       = CNT_W'(FLEN_W - 1);
          state_nxt     = ST_DIV_LAST;
        end
      end

      ST_DIV_LAST: begin
        dvd_nxt = {dvd_r[TIME_W-2:0], 1'b0};
        rem_nxt = rem_step;
        quo_nxt = quo_step;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          last_nxt  = quo_step[SLOT_W-1:0] - SLOT_W'(1);
          state_nxt = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          emit      = 1'b1;
          state_nxt = ST_IDLE;
          if (idle_tick_r) begin
            phase_nxt = PH_IDLE;
            act       = ACT_WAIT;
            offset    = '0;
          end else if (new_slot) begin
            cur_frame_nxt    = frame_calc_r;
            cur_slot_nxt     = slot_calc_r;
            slot_known_nxt   = 1'b1;
            phase_nxt        = PH_SLOT_START;
            channel_done_nxt = 1'b1;
            radio_on_nxt     = 1'b0;
            edge_pending_nxt = 1'b0;
            role_nxt         = asg_role;
            sender_nxt       = asg_sender;
            act              = ACT_SET_CHANNEL;
          end else if (in_settle_zone) begin
            // guard at slot end, settling past the turnaround window
            if (phase_r != (in_guard ? PH_GUARD : PH_SETTLING)) begin
              phase_nxt        = in_guard ? PH_GUARD : PH_SETTLING;
              radio_on_nxt     = 1'b0;
              edge_pending_nxt = 1'b0;
              act              = ACT_STOP;
            end
          end else if (!channel_done_r) begin
            phase_nxt        = PH_SWITCH;
            channel_done_nxt = 1'b1;
            act              = ACT_SET_CHANNEL;
          end else if (role_r == ROLE_UNUSED) begin
            phase_nxt = PH_SLOT_DONE;
          end else if (!radio_on_r) begin
            radio_on_nxt = 1'b1;
            if (role_r == ROLE_JOIN) begin
              // joiners transmit, the master listens, others sit out
              if (local_node_r == ADDR_UNASSIGNED) begin
                phase_nxt = PH_TX;
                act       = ACT_START_TX;
              end else if (local_node_r == ADDR_MASTER) begin
                phase_nxt = PH_RX;
                act       = ACT_START_RX;
              end else begin
                phase_nxt = PH_SLOT_DONE;
              end
            end else if (sender_r == local_node_r) begin
              phase_nxt = PH_TX;
              act       = ACT_START_TX;
            end else begin
              phase_nxt = PH_RX;
              act       = ACT_START_RX;
            end
          end else if (edge_pending_r) begin
            // an edge in any other phase is dropped
            edge_pending_nxt = 1'b0;
            if (phase_r == PH_RX) begin
              phase_nxt = PH_RX_DONE;
              act       = ACT_LOG_RX;
            end else if (phase_r == PH_TX) begin
              phase_nxt = PH_TX_DONE;
              act       = ACT_STOP;
            end
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_item_nxt              = out_item_r;
    out_valid_nxt             = out_valid_r & ~out_ready;
    if (emit) begin
      out_valid_nxt             = 1'b1;
      out_item_nxt.action       = act;
      out_item_nxt.phase        = phase_nxt;
      out_item_nxt.frame_number = cur_frame_nxt;
      out_item_nxt.slot_number  = cur_slot_nxt;
      out_item_nxt.slot_offset  = offset;
      out_item_nxt.we_transmit  = (sender_nxt == local_node_r);
      out_item_nxt.slot_role    = role_nxt;
      out_item_nxt.transmitter  = sender_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      cur_frame_r    <= '0;
      cur_slot_r     <= '1;
      slot_known_r   <= 1'b0;
      phase_r        <= PH_IDLE;
      role_r         <= ROLE_UNUSED;
      sender_r       <= '0;
      channel_done_r <= 1'b0;
      radio_on_r     <= 1'b0;
      edge_pending_r <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      cur_frame_r    <= cur_frame_nxt;
      cur_slot_r     <= cur_slot_nxt;
      slot_known_r   <= slot_known_nxt;
      phase_r        <= phase_nxt;
      role_r         <= role_nxt;
      sender_r       <= sender_nxt;
      channel_done_r <= channel_done_nxt;
      radio_on_r     <= radio_on_nxt;
      edge_pending_r <= edge_pending_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    dvd_r        <= dvd_nxt;
    rem_r        <= rem_nxt;
    dvs_r        <= dvs_nxt;
    quo_r        <= quo_nxt;
    cnt_r        <= cnt_nxt;
    idle_tick_r  <= idle_tick_nxt;
    frame_calc_r <= frame_calc_nxt;
    slot_calc_r  <= slot_calc_nxt;
    spos_r       <= spos_nxt;
    last_r       <= last_nxt;
    out_item_r   <= out_item_nxt;
  end

endmodule
